/* src/stl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types and constants of the source token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

	typedef struct packed {
		logic       func;
		logic [6:0] char_byte;
	} stl_in_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [31:0] start_offset;
		logic [31:0] span_length;
		logic [1:0]  diag_code;
		logic        run_last;
	} stl_out_t;

	localparam logic [5:0] K_IDENT   = 6'd0;
	localparam logic [5:0] K_INT     = 6'd1;
	localparam logic [5:0] K_FLOAT   = 6'd2;
	localparam logic [5:0] K_STRING  = 6'd3;
	localparam logic [5:0] K_SLASH   = 6'd17;
	localparam logic [5:0] K_DOT     = 6'd19;
	localparam logic [5:0] K_DOTDOT  = 6'd20;
	localparam logic [5:0] K_BANG    = 6'd21;
	localparam logic [5:0] K_ASSIGN  = 6'd23;
	localparam logic [5:0] K_LT      = 6'd26;
	localparam logic [5:0] K_GT      = 6'd28;
	localparam logic [5:0] K_INVALID = 6'd32;
	localparam logic [5:0] K_END     = 6'd33;
	localparam logic [5:0] K_DIAG    = 6'd34;

	localparam logic [1:0] D_NONE  = 2'd0;
	localparam logic [1:0] D_CHAR  = 2'd1;
	localparam logic [1:0] D_BLOCK = 2'd2;
	localparam logic [1:0] D_STR   = 2'd3;

	// configuration register addresses
	localparam logic [1:0] A_BASE = 2'd0;

	// scan modes, one-hot
	typedef enum logic [15:0] {
		M_IDLE       = 16'h0001,
		M_IDENT      = 16'h0002,
		M_ZERO       = 16'h0004,
		M_INT        = 16'h0008,
		M_DOT        = 16'h0010,
		M_FRAC       = 16'h0020,
		M_ESIGN      = 16'h0040,
		M_EXP        = 16'h0080,
		M_HEX        = 16'h0100,
		M_SUFFIX     = 16'h0200,
		M_STR        = 16'h0400,
		M_STR_ESC    = 16'h0800,
		M_OP         = 16'h1000,
		M_LINE       = 16'h2000,
		M_BLOCK      = 16'h4000,
		M_BLOCK_STAR = 16'h8000
	} mode_t;

	// one token record before offsets are finalized
	typedef struct packed {
		logic       vld;
		logic [5:0] kind;
		logic [1:0] sel;   // start: 0 token_begin, 1 pos, 2 pos-1
		logic [1:0] span;  // span: 0 pos-begin, 1 literal, 2 pos-1-begin, 3 pos+1-begin
		logic [1:0] lit;   // literal span value
		logic [1:0] diag;
	} rec_t;

	localparam logic [1:0] S_BEGIN = 2'd0;
	localparam logic [1:0] S_POS   = 2'd1;
	localparam logic [1:0] S_POSM1 = 2'd2;
	localparam logic [1:0] L_DIFF  = 2'd0;
	localparam logic [1:0] L_LIT   = 2'd1;
	localparam logic [1:0] L_DIFFM = 2'd2;
	localparam logic [1:0] L_DIFFP = 2'd3;

	function automatic logic is_letter(logic [6:0] c);
		return (c >= 7'h61 && c <= 7'h7a) || (c >= 7'h41 && c <= 7'h5a);
	endfunction
	function automatic logic is_digit(logic [6:0] c);
		return c >= 7'h30 && c <= 7'h39;
	endfunction
	function automatic logic is_space(logic [6:0] c);
		return c == 7'h20 || (c >= 7'd9 && c <= 7'd13);
	endfunction
	function automatic logic is_hex(logic [6:0] c);
		return is_digit(c) || (c >= 7'h61 && c <= 7'h66) || (c >= 7'h41 && c <= 7'h46);
	endfunction

	// single-character punctuator kind, or invalid
	function automatic logic [5:0] single_kind(logic [6:0] c);
		logic [5:0] k;
		unique case (c)
			7'h7b: k = 6'd4;
			7'h7d: k = 6'd5;
			7'h28: k = 6'd6;
			7'h29: k = 6'd7;
			7'h5b: k = 6'd8;
			7'h5d: k = 6'd9;
			7'h3a: k = 6'd10;
			7'h2c: k = 6'd11;
			7'h40: k = 6'd12;
			7'h3b: k = 6'd13;
			7'h2b: k = 6'd14;
			7'h2d: k = 6'd15;
			7'h2a: k = 6'd16;
			7'h25: k = 6'd18;
			default: k = K_INVALID;
		endcase
		return k;
	endfunction

	function automatic logic is_opstart(logic [6:0] c);
		return c == 7'h2f || c == 7'h2e || c == 7'h21 || c == 7'h3d ||
			c == 7'h3c || c == 7'h3e || c == 7'h26 || c == 7'h7c;
	endfunction

	// two-character operator, K_INVALID when none
	function automatic logic [5:0] pair_kind(logic [6:0] h, logic [6:0] c);
		logic [5:0] k;
		k = K_INVALID;
		if (h == 7'h2e && c == 7'h2e) k = K_DOTDOT;
		if (h == 7'h21 && c == 7'h3d) k = 6'd22;
		if (h == 7'h3d && c == 7'h3d) k = 6'd24;
		if (h == 7'h3d && c == 7'h3e) k = 6'd25;
		if (h == 7'h3c && c == 7'h3d) k = 6'd27;
		if (h == 7'h3e && c == 7'h3d) k = 6'd29;
		if (h == 7'h26 && c == 7'h26) k = 6'd30;
		if (h == 7'h7c && c == 7'h7c) k = 6'd31;
		return k;
	endfunction

	function automatic logic [5:0] held_kind(logic [6:0] h);
		logic [5:0] k;
		unique case (h)
			7'h2f: k = K_SLASH;
			7'h2e: k = K_DOT;
			7'h21: k = K_BANG;
			7'h3d: k = K_ASSIGN;
			7'h3c: k = K_LT;
			7'h3e: k = K_GT;
			default: k = K_INVALID;
		endcase
		return k;
	endfunction

endpackage

/* src/source_token_lexer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_token_lexer_core
// Streaming tokenizer, one character per item, up to three tokens per item.
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  stl_in_t  (func, char_byte)
//  out      output     out_valid/out_stall stl_out_t (kind, offset, span, diag, last)
//  apb      input      psel/penable/...   base_offset at address 0
//
// An item that yields zero or one token is taken every cycle while out_stall
// is low. An item that yields several tokens holds the input while the result
// register drains one token per cycle unless out_stall is high. Reset clears scan
// state and base_offset. Output stalls back up into the input through in_stall.
// ----------------------------------------------------------------------------
module source_token_lexer_core #(
	parameter int OFFSET_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  stl_pkg::stl_in_t   in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output stl_pkg::stl_out_t  out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import stl_pkg::*;

	logic [31:0]            base_q;
	logic                   busy;
	logic                   acc;
	rec_t                   rec0, rec1, rec2;
	logic [OFFSET_BITS-1:0] pos, tbeg;

	assign pready   = 1'b1;
	assign prdata   = (paddr == A_BASE) ? base_q : '0;
	assign in_stall = busy;
	assign acc      = in_valid && !busy;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) base_q <= '0;
		else if (psel && penable && pwrite && paddr == A_BASE) base_q <= pwdata;
	end

	stl_scan #(.OFFSET_BITS(OFFSET_BITS)) u_scan (
		.clk(clk), .arst_n(arst_n), .adv(acc), .item(in_data),
		.rec0(rec0), .rec1(rec1), .rec2(rec2), .pos(pos), .tbeg(tbeg)
	);

	stl_emit #(.OFFSET_BITS(OFFSET_BITS)) u_emit (
		.clk(clk), .arst_n(arst_n), .load(acc), .rec0(rec0), .rec1(rec1),
		.rec2(rec2), .pos(pos), .tbeg(tbeg), .base(base_q),
		.out_stall(out_stall), .out_valid(out_valid), .out_data(out_data),
		.busy(busy)
	);

`ifndef SYNTHESIS
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output blocked");
	a_ready: assert property (@(posedge clk) pready)
		else $error("pready low");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("stall without pending output");
`endif

endmodule

/* src/stl_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_scan
// Scanner state and next-state logic: up to three token records per item.
// ----------------------------------------------------------------------------
module stl_scan #(
	parameter int OFFSET_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  stl_pkg::stl_in_t       item,
	output stl_pkg::rec_t          rec0,
	output stl_pkg::rec_t          rec1,
	output stl_pkg::rec_t          rec2,
	output logic [OFFSET_BITS-1:0] pos,
	output logic [OFFSET_BITS-1:0] tbeg
);
	import stl_pkg::*;

	mode_t                  mode_q, mode_d;
	logic [OFFSET_BITS-1:0] pos_q, beg_q, beg_d;
	logic [6:0]             held_q, held_d;
	logic                   flt_q, flt_d;
	logic [6:0]             c;
	rec_t                   r [3];
	logic [1:0]             n;
	logic [5:0]             pk;

	assign c    = item.char_byte;
	assign pos  = pos_q;
	assign tbeg = beg_q;
	assign rec0 = r[0];
	assign rec1 = r[1];
	assign rec2 = r[2];

	// next state and records
	always_comb begin
		logic do_idle;
		logic num_end;
		rec_t t;
		mode_d  = mode_q;
		beg_d   = beg_q;
		held_d  = held_q;
		flt_d   = flt_q;
		n       = 2'd0;
		do_idle = 1'b0;
		num_end = 1'b0;
		pk      = pair_kind(held_q, c);
		r[0] = '0;
		r[1] = '0;
		r[2] = '0;
		t    = '0;
		if (item.func) begin
			unique case (mode_q)
				M_IDENT: begin
					r[0] = '{1'b1, K_IDENT, S_BEGIN, L_DIFF, 2'd0, D_NONE};
					n = 2'd1;
				end
				M_ZERO, M_INT, M_FRAC, M_ESIGN, M_EXP, M_HEX, M_SUFFIX: begin
					r[0] = '{1'b1, flt_q ? K_FLOAT : K_INT, S_BEGIN, L_DIFF, 2'd0, D_NONE};
					n = 2'd1;
				end
				M_DOT: begin
					r[0] = '{1'b1, K_INT, S_BEGIN, L_DIFFM, 2'd0, D_NONE};
					r[1] = '{1'b1, K_DOT, S_POSM1, L_LIT, 2'd1, D_NONE};
					n = 2'd2;
				end
				M_STR, M_STR_ESC: begin
					r[0] = '{1'b1, K_STRING, S_BEGIN, L_DIFF, 2'd0, D_STR};
					n = 2'd1;
				end
				M_OP: begin
					r[0] = '{1'b1, held_kind(held_q), S_BEGIN, L_LIT, 2'd1,
						held_kind(held_q) == K_INVALID ? D_CHAR : D_NONE};
					n = 2'd1;
				end
				M_BLOCK, M_BLOCK_STAR: begin
					r[0] = '{1'b1, K_DIAG, S_BEGIN, L_DIFF, 2'd0, D_BLOCK};
					n = 2'd1;
				end
				default: n = 2'd0;
			endcase
			r[n] = '{1'b1, K_END, S_POS, L_LIT, 2'd0, D_NONE};
			mode_d = M_IDLE;
			beg_d  = '0;
			held_d = '0;
			flt_d  = 1'b0;
		end else begin
			unique case (mode_q)
				M_IDENT: begin
					if (!(is_letter(c) || is_digit(c) || c == 7'h5f)) begin
						r[0] = '{1'b1, K_IDENT, S_BEGIN, L_DIFF, 2'd0, D_NONE};
						n = 2'd1;
						do_idle = 1'b1;
					end
				end
				M_ZERO, M_INT: begin
					if (mode_q == M_ZERO && (c == 7'h78 || c == 7'h58)) mode_d = M_HEX;
					else begin
						mode_d = M_INT;
						if (is_digit(c) || c == 7'h5f) mode_d = M_INT;
						else if (c == 7'h2e) begin
							mode_d = M_DOT;
							held_d = c;
						end else if (c == 7'h65 || c == 7'h45) begin
							flt_d  = 1'b1;
							mode_d = M_ESIGN;
						end else if (is_letter(c)) mode_d = M_SUFFIX;
						else num_end = 1'b1;
					end
				end
				M_DOT: begin
					held_d = '0;
					if (is_digit(c)) begin
						flt_d  = 1'b1;
						mode_d = M_FRAC;
					end else begin
						r[0] = '{1'b1, K_INT, S_BEGIN, L_DIFFM, 2'd0, D_NONE};
						if (c == 7'h2e) begin
							r[1] = '{1'b1, K_DOTDOT, S_POSM1, L_LIT, 2'd2, D_NONE};
							n = 2'd2;
							mode_d = M_IDLE;
						end else begin
							r[1] = '{1'b1, K_DOT, S_POSM1, L_LIT, 2'd1, D_NONE};
							n = 2'd2;
							do_idle = 1'b1;
						end
					end
				end
				M_FRAC: begin
					if (is_digit(c) || c == 7'h5f) mode_d = M_FRAC;
					else if (c == 7'h65 || c == 7'h45) mode_d = M_ESIGN;
					else if (is_letter(c)) mode_d = M_SUFFIX;
					else num_end = 1'b1;
				end
				M_ESIGN: begin
					if (c == 7'h2b || c == 7'h2d || is_digit(c) || c == 7'h5f) mode_d = M_EXP;
					else if (is_letter(c)) mode_d = M_SUFFIX;
					else num_end = 1'b1;
				end
				M_EXP: begin
					if (is_digit(c) || c == 7'h5f) mode_d = M_EXP;
					else if (is_letter(c)) mode_d = M_SUFFIX;
					else num_end = 1'b1;
				end
				M_HEX: begin
					if (is_hex(c) || c == 7'h5f) mode_d = M_HEX;
					else if (is_letter(c)) mode_d = M_SUFFIX;
					else num_end = 1'b1;
				end
				M_SUFFIX: begin
					if (!is_letter(c)) num_end = 1'b1;
				end
				M_STR: begin
					if (c == 7'h5c) mode_d = M_STR_ESC;
					else if (c == 7'h22) begin
						r[0] = '{1'b1, K_STRING, S_BEGIN, L_DIFFP, 2'd0, D_NONE};
						n = 2'd1;
						mode_d = M_IDLE;
					end
				end
				M_STR_ESC: mode_d = M_STR;
				M_OP: begin
					if (held_q == 7'h2f && (c == 7'h2f || c == 7'h2a)) begin
						held_d = '0;
						mode_d = (c == 7'h2f) ? M_LINE : M_BLOCK;
					end else if (pk != K_INVALID) begin
						r[0] = '{1'b1, pk, S_BEGIN, L_LIT, 2'd2, D_NONE};
						n = 2'd1;
						held_d = '0;
						mode_d = M_IDLE;
					end else begin
						r[0] = '{1'b1, held_kind(held_q), S_BEGIN, L_LIT, 2'd1,
							held_kind(held_q) == K_INVALID ? D_CHAR : D_NONE};
						n = 2'd1;
						held_d = '0;
						do_idle = 1'b1;
					end
				end
				M_LINE: if (c == 7'h0a) mode_d = M_IDLE;
				M_BLOCK: if (c == 7'h2a) mode_d = M_BLOCK_STAR;
				M_BLOCK_STAR: begin
					if (c == 7'h2f) mode_d = M_IDLE;
					else if (c != 7'h2a) mode_d = M_BLOCK;
				end
				default: do_idle = 1'b1;
			endcase
			if (num_end) begin
				r[0] = '{1'b1, flt_q ? K_FLOAT : K_INT, S_BEGIN, L_DIFF, 2'd0, D_NONE};
				n = 2'd1;
				do_idle = 1'b1;
			end
			// start a new token from idle
			if (do_idle) begin
				mode_d = M_IDLE;
				if (!is_space(c)) begin
					beg_d = pos_q;
					if (is_letter(c) || c == 7'h5f) mode_d = M_IDENT;
					else if (is_digit(c)) begin
						flt_d  = 1'b0;
						mode_d = (c == 7'h30) ? M_ZERO : M_INT;
					end else if (c == 7'h22) mode_d = M_STR;
					else if (is_opstart(c)) begin
						held_d = c;
						mode_d = M_OP;
					end else begin
						t = '{1'b1, single_kind(c), S_POS, L_LIT, 2'd1,
							single_kind(c) == K_INVALID ? D_CHAR : D_NONE};
						r[n] = t;
					end
				end
			end
		end
	end

	// advance state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q  <= '0;
			beg_q  <= '0;
			held_q <= '0;
			flt_q  <= 1'b0;
		end else if (adv) begin
			mode_q <= mode_d;
			beg_q  <= beg_d;
			held_q <= held_d;
			flt_q  <= flt_d;
			pos_q  <= item.func ? '0 : pos_q + 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item.func |=> mode_q == M_IDLE && pos_q == '0)
		else $error("end item did not clear scan state");
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !item.func |=> pos_q == $past(pos_q) + 1'b1)
		else $error("position did not advance");
	a_held_op: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == M_OP |-> held_q != '0)
		else $error("operator mode without held char");
`endif

endmodule

/* src/stl_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_emit
// Result register: latches up to three records and drains one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module stl_emit #(
	parameter int OFFSET_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  stl_pkg::rec_t          rec0,
	input  stl_pkg::rec_t          rec1,
	input  stl_pkg::rec_t          rec2,
	input  logic [OFFSET_BITS-1:0] pos,
	input  logic [OFFSET_BITS-1:0] tbeg,
	input  logic [31:0]            base,
	input  logic                   out_stall,
	output logic                   out_valid,
	output stl_pkg::stl_out_t      out_data,
	output logic                   busy
);
	import stl_pkg::*;

	stl_out_t   buf_q [3];
	logic [1:0] cnt_q;
	logic [1:0] head_q;
	stl_out_t   f [3];
	logic [1:0] nrec;
	logic       pop;

	// finish one record: offsets and spans at full position width
	function automatic stl_out_t fin(rec_t r, logic [OFFSET_BITS-1:0] p,
		logic [OFFSET_BITS-1:0] b, logic [31:0] bo, logic last);
		stl_out_t o;
		logic [OFFSET_BITS-1:0] st;
		logic [OFFSET_BITS-1:0] sp;
		unique case (r.sel)
			S_POS:   st = p;
			S_POSM1: st = p - 1'b1;
			default: st = b;
		endcase
		unique case (r.span)
			L_LIT:   sp = OFFSET_BITS'(r.lit);
			L_DIFFM: sp = p - 1'b1 - b;
			L_DIFFP: sp = p + 1'b1 - b;
			default: sp = p - b;
		endcase
		o.token_kind   = r.kind;
		o.start_offset = bo + 32'(st);
		o.span_length  = 32'(sp);
		o.diag_code    = r.diag;
		o.run_last     = last;
		return o;
	endfunction

	assign nrec = 2'(rec0.vld) + 2'(rec1.vld) + 2'(rec2.vld);
	assign f[0] = fin(rec0, pos, tbeg, base, !rec1.vld);
	assign f[1] = fin(rec1, pos, tbeg, base, !rec2.vld);
	assign f[2] = fin(rec2, pos, tbeg, base, 1'b1);

	assign out_valid = cnt_q != 2'd0;
	assign out_data  = buf_q[head_q];
	assign pop       = out_valid && !out_stall;
	assign busy      = (cnt_q > 2'd1) || (cnt_q == 2'd1 && !pop);

	// hold records, drain in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			head_q <= '0;
		end else if (load) begin
			cnt_q  <= nrec;
			head_q <= '0;
		end else if (pop) begin
			cnt_q  <= cnt_q - 1'b1;
			head_q <= head_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q[0] <= f[0];
			buf_q[1] <= f[1];
			buf_q[2] <= f[2];
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd3)
		else $error("record count out of range");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !busy)
		else $error("records overwritten before delivery");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !load |=> cnt_q == $past(cnt_q) - 2'd1)
		else $error("pop did not drain");
`endif

endmodule
